// File: rtl/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types, register indexes and a helper function for the Barrett
// modular multiplier.
// ----------------------------------------------------------------------------
package bmm_pkg;

	localparam int WORD_W  = 64;
	localparam int HALF_W  = 32;
	localparam int SHAMT_W = 6;
	localparam int CIDX_W  = 3;

	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [2*WORD_W-1:0] dword_t;
	typedef logic [HALF_W-1:0]   half_t;
	typedef logic [SHAMT_W-1:0]  shamt_t;
	typedef logic [CIDX_W-1:0]   cidx_t;

	localparam cidx_t REG_MODULUS = 3'd0;
	localparam cidx_t REG_MU      = 3'd1;
	localparam cidx_t REG_SR1     = 3'd2;
	localparam cidx_t REG_SL1     = 3'd3;
	localparam cidx_t REG_SR2     = 3'd4;
	localparam cidx_t REG_SL2     = 3'd5;

	// 64-bit window from a 128-bit value: (lo >> rs) | (hi << ls)
	function automatic word_t window_f(input dword_t v, input shamt_t rs, input shamt_t ls);
		word_t lo;
		word_t hi;
		lo = v[WORD_W-1:0];
		hi = v[2*WORD_W-1:WORD_W];
		return (lo >> rs) | (hi << ls);
	endfunction

endpackage

// File: rtl/bmm_mul64.sv
// ----------------------------------------------------------------------------
// bmm_mul64
// Two-stage 64x64 unsigned multiplier: four 32x32 partial products in the
// first stage, their 128-bit sum in the second.
// ----------------------------------------------------------------------------
module bmm_mul64 (
	input  logic           clk,
	input  logic           en,
	input  bmm_pkg::word_t  x,
	input  bmm_pkg::word_t  y,
	output bmm_pkg::dword_t p
);

	bmm_pkg::word_t  ll_s1;
	bmm_pkg::word_t  lh_s1;
	bmm_pkg::word_t  hl_s1;
	bmm_pkg::word_t  hh_s1;
	bmm_pkg::dword_t p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= bmm_pkg::word_t'(x[31:0])  * bmm_pkg::word_t'(y[31:0]);
			lh_s1 <= bmm_pkg::word_t'(x[31:0])  * bmm_pkg::word_t'(y[63:32]);
			hl_s1 <= bmm_pkg::word_t'(x[63:32]) * bmm_pkg::word_t'(y[31:0]);
			hh_s1 <= bmm_pkg::word_t'(x[63:32]) * bmm_pkg::word_t'(y[63:32]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= {hh_s1, ll_s1}
				+ {32'd0, lh_s1, 32'd0}
				+ {32'd0, hl_s1, 32'd0};
		end
	end

	assign p = p_s2;

endmodule

// File: rtl/barrett_modular_multiplier.sv
// ----------------------------------------------------------------------------
// barrett_modular_multiplier
// Pipelined 64-bit modular multiplication by Barrett reduction with
// configurable modulus, constant and window shifts.
// ----------------------------------------------------------------------------
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, operand_a/b, last_in  | sink
//  out     | out_valid/out_ready, product_mod, last_out | source
//  cfg     | cfg_write, cfg_index, cfg_data          | sink, no wait
//
//  One transfer per cycle in each direction while the output is not stalled.
//  All stages advance together; a stalled output freezes the whole pipe.
//  Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module barrett_modular_multiplier (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  bmm_pkg::cidx_t         cfg_index,
	input  bmm_pkg::word_t         cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  bmm_pkg::word_t         operand_a,
	input  bmm_pkg::word_t         operand_b,
	input  logic                   last_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output bmm_pkg::word_t         product_mod,
	output logic                   last_out
);

	localparam int NSTG = 11;

	bmm_pkg::word_t  modulus_q;
	bmm_pkg::word_t  mu_q;
	bmm_pkg::shamt_t sr1_q;
	bmm_pkg::shamt_t sl1_q;
	bmm_pkg::shamt_t sr2_q;
	bmm_pkg::shamt_t sl2_q;

	logic [NSTG:1]   vld_q;
	logic [NSTG:1]   last_q;
	logic            adv;

	bmm_pkg::dword_t prod1;
	bmm_pkg::dword_t prod2;

	bmm_pkg::word_t  w_s3;
	bmm_pkg::word_t  lo_s3;
	bmm_pkg::word_t  lo_s4;
	bmm_pkg::word_t  lo_s5;
	bmm_pkg::word_t  est_s6;
	bmm_pkg::word_t  lo_s6;
	bmm_pkg::word_t  pll_s7;
	bmm_pkg::half_t  plh_s7;
	bmm_pkg::half_t  phl_s7;
	bmm_pkg::word_t  lo_s7;
	bmm_pkg::word_t  m_s8;
	bmm_pkg::word_t  lo_s8;
	bmm_pkg::word_t  r_s9;
	bmm_pkg::word_t  r_s10;
	bmm_pkg::word_t  r_s11;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 64'd1;
			mu_q      <= '0;
			sr1_q     <= '0;
			sl1_q     <= '0;
			sr2_q     <= '0;
			sl2_q     <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bmm_pkg::REG_MODULUS: modulus_q <= cfg_data;
				bmm_pkg::REG_MU:      mu_q      <= cfg_data;
				bmm_pkg::REG_SR1:     sr1_q     <= cfg_data[5:0];
				bmm_pkg::REG_SL1:     sl1_q     <= cfg_data[5:0];
				bmm_pkg::REG_SR2:     sr2_q     <= cfg_data[5:0];
				bmm_pkg::REG_SL2:     sl2_q     <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// flow control
	assign adv      = !vld_q[NSTG] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_q <= {last_q[NSTG-1:1], last_in};
		end
	end

	// a * b, stages 1-2
	bmm_mul64 u_mul_ab (
		.clk (clk),
		.en  (adv),
		.x   (operand_a),
		.y   (operand_b),
		.p   (prod1)
	);

	// first window, stage 3
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3  <= bmm_pkg::window_f(prod1, sr1_q, sl1_q);
			lo_s3 <= prod1[63:0];
		end
	end

	// w * mu, stages 4-5
	bmm_mul64 u_mul_wmu (
		.clk (clk),
		.en  (adv),
		.x   (w_s3),
		.y   (mu_q),
		.p   (prod2)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s4 <= lo_s3;
			lo_s5 <= lo_s4;
		end
	end

	// quotient estimate, stage 6
	always_ff @(posedge clk) begin
		if (adv) begin
			est_s6 <= bmm_pkg::window_f(prod2, sr2_q, sl2_q);
			lo_s6  <= lo_s5;
		end
	end

	// low 64 bits of est * q: partial products, stage 7
	always_ff @(posedge clk) begin
		if (adv) begin
			pll_s7 <= bmm_pkg::word_t'(est_s6[31:0]) * bmm_pkg::word_t'(modulus_q[31:0]);
			plh_s7 <= est_s6[31:0]  * modulus_q[63:32];
			phl_s7 <= est_s6[63:32] * modulus_q[31:0];
			lo_s7  <= lo_s6;
		end
	end

	// stage 8: sum, stage 9: subtract from low product
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s8  <= pll_s7 + {plh_s7 + phl_s7, 32'd0};
			lo_s8 <= lo_s7;
			r_s9  <= lo_s8 - m_s8;
		end
	end

	// two conditional corrections, stages 10-11
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s10 <= (r_s9 >= modulus_q) ? r_s9 - modulus_q : r_s9;
			r_s11 <= (r_s10 >= modulus_q) ? r_s10 - modulus_q : r_s10;
		end
	end

	assign out_valid   = vld_q[NSTG];
	assign product_mod = r_s11;
	assign last_out    = last_q[NSTG];

endmodule
